// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the clock and masked during reset.
`define AST_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the clock and masked during reset.
`define AST_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is also checked while reset is high.
`define AST_ALWAYS_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/hcg_pkg.sv =====
// Types, constants and gradient tables of the height colormap unit.
`timescale 1ns / 1ps

package hcg_pkg;

   localparam int FRAC_BITS = 16;
   localparam int R_W       = FRAC_BITS + 1;
   localparam int POS_W     = FRAC_BITS + 1;
   localparam int DIV_W     = (FRAC_BITS > 15) ? FRAC_BITS : 15;
   localparam int CMP_W     = (R_W > DIV_W) ? R_W : DIV_W;
   localparam int PROD_W    = 8 + POS_W;
   localparam int DIV_STEPS  = 4;
   localparam int DIV_STAGES = (FRAC_BITS + DIV_STEPS - 1) / DIV_STEPS;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_HEIGHT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_HEIGHT = 1'b1;

   localparam logic [POS_W-1:0] ONE_Q = POS_W'(64'd1 << FRAC_BITS);

   // Breakpoints in permille, rounded to the nearest Q1.FRAC_BITS step.
   localparam logic [R_W-1:0] BRK_2   = R_W'(((64'd2 << FRAC_BITS) + 64'd500) / 64'd1000);
   localparam logic [R_W-1:0] BRK_30  = R_W'(((64'd30 << FRAC_BITS) + 64'd500) / 64'd1000);
   localparam logic [R_W-1:0] BRK_100 = R_W'(((64'd100 << FRAC_BITS) + 64'd500) / 64'd1000);
   localparam logic [R_W-1:0] BRK_400 = R_W'(((64'd400 << FRAC_BITS) + 64'd500) / 64'd1000);
   localparam logic [R_W-1:0] BRK_MAX = R_W'(64'd1 << FRAC_BITS);

   localparam logic [2:0] SEG_0 = 3'd0;
   localparam logic [2:0] SEG_1 = 3'd1;
   localparam logic [2:0] SEG_2 = 3'd2;
   localparam logic [2:0] SEG_3 = 3'd3;
   localparam logic [2:0] SEG_4 = 3'd4;
   localparam logic [2:0] SEG_END = 3'd5;

   localparam logic [23:0] BASE_COLOR = 24'h00307f;

   typedef struct packed {
      logic       bad;
      logic       gt_min;
      logic       pos_z;
      logic       sat;
      logic       ibit;
      logic       use_base;
      logic [2:0] seg;
   } side_type;

   typedef struct packed {
      logic [FRAC_BITS-1:0] quo;
      logic [DIV_W-1:0]     rem;
   } div_state_type;

   function automatic logic [23:0] seg_color(input logic [2:0] idx);
      logic [23:0] c;
      unique case (idx)
         SEG_0:   c = BASE_COLOR;
         SEG_1:   c = 24'h087c00;
         SEG_2:   c = 24'h055100;
         SEG_3:   c = 24'h603d00;
         SEG_4:   c = 24'h685c47;
         SEG_END: c = 24'hffffff;
         default: c = BASE_COLOR;
      endcase
      return c;
   endfunction

   function automatic logic [R_W-1:0] seg_lo(input logic [2:0] idx);
      logic [R_W-1:0] v;
      unique case (idx)
         SEG_0:   v = '0;
         SEG_1:   v = BRK_2;
         SEG_2:   v = BRK_30;
         SEG_3:   v = BRK_100;
         SEG_4:   v = BRK_400;
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic logic [DIV_W-1:0] seg_width(input logic [2:0] idx);
      logic [R_W-1:0] v;
      unique case (idx)
         SEG_0:   v = BRK_2;
         SEG_1:   v = BRK_30 - BRK_2;
         SEG_2:   v = BRK_100 - BRK_30;
         SEG_3:   v = BRK_400 - BRK_100;
         SEG_4:   v = BRK_MAX - BRK_400;
         default: v = R_W'(1);
      endcase
      return DIV_W'(v);
   endfunction

endpackage

// ===== sv/hcg_divider.sv =====
// Pipelined restoring divider producing the fraction bits of rem / div.
`timescale 1ns / 1ps

module hcg_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [hcg_pkg::DIV_W-1:0]       in_rem,
   input  logic [hcg_pkg::DIV_W-1:0]       in_div,
   input  hcg_pkg::side_type               in_side,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic [hcg_pkg::FRAC_BITS-1:0]   out_quo,
   output hcg_pkg::side_type               out_side
);

   // The remainder always stays below the divisor, so one doubling fits DIV_W + 1 bits.
   function automatic hcg_pkg::div_state_type div_steps(
      input hcg_pkg::div_state_type s,
      input logic [hcg_pkg::DIV_W-1:0] dv,
      input int n
   );
      logic [hcg_pkg::DIV_W:0] sh;
      hcg_pkg::div_state_type  t;
      t = s;
      for (int j = 0; j < hcg_pkg::DIV_STEPS; j++) begin
         if (j < n) begin
            sh = {t.rem, 1'b0};
            if (sh >= {1'b0, dv}) begin
               t.rem = hcg_pkg::DIV_W'(sh - {1'b0, dv});
               t.quo = {t.quo[hcg_pkg::FRAC_BITS-2:0], 1'b1};
            end else begin
               t.rem = hcg_pkg::DIV_W'(sh);
               t.quo = {t.quo[hcg_pkg::FRAC_BITS-2:0], 1'b0};
            end
         end
      end
      return t;
   endfunction

   logic                    valid_ff    [hcg_pkg::DIV_STAGES];
   hcg_pkg::div_state_type  state_ff    [hcg_pkg::DIV_STAGES];
   logic [hcg_pkg::DIV_W-1:0] div_ff    [hcg_pkg::DIV_STAGES];
   hcg_pkg::side_type       side_ff     [hcg_pkg::DIV_STAGES];
   logic                    stage_ready [hcg_pkg::DIV_STAGES];

   for (genvar st = 0; st < hcg_pkg::DIV_STAGES; st++) begin : g_stage
      localparam int NSTEP =
         ((hcg_pkg::FRAC_BITS - st * hcg_pkg::DIV_STEPS) < hcg_pkg::DIV_STEPS) ?
         (hcg_pkg::FRAC_BITS - st * hcg_pkg::DIV_STEPS) : hcg_pkg::DIV_STEPS;

      logic                      valid_src;
      hcg_pkg::div_state_type    state_src;
      logic [hcg_pkg::DIV_W-1:0] div_src;
      hcg_pkg::side_type         side_src;
      logic                      next_ready;
      hcg_pkg::div_state_type    state_in;

      if (st == 0) begin : g_first
         assign valid_src     = in_valid;
         assign state_src.quo = '0;
         assign state_src.rem = in_rem;
         assign div_src       = in_div;
         assign side_src      = in_side;
      end else begin : g_next
         assign valid_src = valid_ff[st-1];
         assign state_src = state_ff[st-1];
         assign div_src   = div_ff[st-1];
         assign side_src  = side_ff[st-1];
      end

      if (st == hcg_pkg::DIV_STAGES - 1) begin : g_tail
         assign next_ready = out_ready;
      end else begin : g_mid
         assign next_ready = stage_ready[st+1];
      end

      assign stage_ready[st] = !valid_ff[st] || next_ready;
      assign state_in        = div_steps(state_src, div_src, NSTEP);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[st] <= 1'b0;
         end else if (stage_ready[st]) begin
            valid_ff[st] <= valid_src;
         end
         if (stage_ready[st] && valid_src) begin
            state_ff[st] <= state_in;
            div_ff[st]   <= div_src;
            side_ff[st]  <= side_src;
         end
      end
   end

   assign in_ready  = stage_ready[0];
   assign out_valid = valid_ff[hcg_pkg::DIV_STAGES-1];
   assign out_quo   = state_ff[hcg_pkg::DIV_STAGES-1].quo;
   assign out_side  = side_ff[hcg_pkg::DIV_STAGES-1];

endmodule

// ===== sv/hcg_segment.sv =====
// Segment selection stage: builds the ratio, picks the segment, sets up the position divide.
`timescale 1ns / 1ps

module hcg_segment (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [hcg_pkg::FRAC_BITS-1:0] in_quo,
   input  hcg_pkg::side_type             in_side,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [hcg_pkg::DIV_W-1:0]     out_rem,
   output logic [hcg_pkg::DIV_W-1:0]     out_div,
   output hcg_pkg::side_type             out_side
);

   logic [hcg_pkg::R_W-1:0]   ratio;
   logic [2:0]                seg;
   logic [hcg_pkg::R_W-1:0]   offset;
   logic [hcg_pkg::DIV_W-1:0] width;
   logic                      over;
   logic                      valid_ff;
   logic [hcg_pkg::DIV_W-1:0] rem_ff, rem_in;
   logic [hcg_pkg::DIV_W-1:0] div_ff;
   hcg_pkg::side_type         side_ff, side_in;

   always_comb begin
      if (!in_side.pos_z) begin
         ratio = '0;
      end else if (in_side.sat) begin
         ratio = '1;
      end else begin
         ratio = {in_side.ibit, in_quo};
      end

      // The last matching segment wins, so test from the top down.
      priority if (ratio >= hcg_pkg::BRK_400) begin
         seg = hcg_pkg::SEG_4;
      end else if (ratio >= hcg_pkg::BRK_100) begin
         seg = hcg_pkg::SEG_3;
      end else if (ratio >= hcg_pkg::BRK_30) begin
         seg = hcg_pkg::SEG_2;
      end else if (ratio >= hcg_pkg::BRK_2) begin
         seg = hcg_pkg::SEG_1;
      end else begin
         seg = hcg_pkg::SEG_0;
      end

      width  = hcg_pkg::seg_width(seg);
      offset = ratio - hcg_pkg::seg_lo(seg);
      // At or past the segment end the position clamps to one.
      over   = hcg_pkg::CMP_W'(offset) >= hcg_pkg::CMP_W'(width);
      rem_in = over ? '0 : hcg_pkg::DIV_W'(offset);

      side_in          = '0;
      side_in.bad      = in_side.bad;
      side_in.sat      = over;
      side_in.seg      = seg;
      side_in.use_base = in_side.bad || ((seg == hcg_pkg::SEG_0) && !in_side.gt_min);
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         rem_ff  <= rem_in;
         div_ff  <= width;
         side_ff <= side_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_div   = div_ff;
   assign out_side  = side_ff;

endmodule

// ===== sv/hcg_blend.sv =====
// Channel interpolation: one multiply stage, then the add stage into the output register.
`timescale 1ns / 1ps

module hcg_blend (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [hcg_pkg::FRAC_BITS-1:0] in_quo,
   input  hcg_pkg::side_type             in_side,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [23:0]                   out_color,
   output logic                          out_bad
);

   logic [hcg_pkg::POS_W-1:0]  pos;
   logic [23:0]                c_lo, c_hi;
   logic [7:0]                 a_in   [3];
   logic                       up_in  [3];
   logic [hcg_pkg::PROD_W-1:0] prod_in[3];

   logic                       mul_valid_ff;
   logic [7:0]                 a_ff   [3];
   logic                       up_ff  [3];
   logic [hcg_pkg::PROD_W-1:0] prod_ff[3];
   logic                       base_ff;
   logic                       bad_ff;
   logic                       mul_ready;

   logic                       out_valid_ff;
   logic [23:0]                color_ff, color_in;
   logic                       out_bad_ff;
   logic [7:0]                 chan   [3];

   always_comb begin
      pos  = in_side.sat ? hcg_pkg::ONE_Q : {1'b0, in_quo};
      c_lo = hcg_pkg::seg_color(in_side.seg);
      c_hi = hcg_pkg::seg_color(3'(in_side.seg + 3'd1));
      for (int ch = 0; ch < 3; ch++) begin
         a_in[ch]  = c_lo[8*ch +: 8];
         up_in[ch] = c_hi[8*ch +: 8] >= c_lo[8*ch +: 8];
         if (up_in[ch]) begin
            prod_in[ch] = hcg_pkg::PROD_W'(c_hi[8*ch +: 8] - c_lo[8*ch +: 8]) *
                          hcg_pkg::PROD_W'(pos);
         end else begin
            prod_in[ch] = hcg_pkg::PROD_W'(c_lo[8*ch +: 8] - c_hi[8*ch +: 8]) *
                          hcg_pkg::PROD_W'(pos);
         end
      end
   end

   // Magnitude times position, truncated, is moved toward the far color.
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         if (up_ff[ch]) begin
            chan[ch] = a_ff[ch] + prod_ff[ch][hcg_pkg::FRAC_BITS +: 8];
         end else begin
            chan[ch] = a_ff[ch] - prod_ff[ch][hcg_pkg::FRAC_BITS +: 8];
         end
      end
      color_in = base_ff ? hcg_pkg::BASE_COLOR : {chan[2], chan[1], chan[0]};
   end

   assign mul_ready = !out_valid_ff || out_ready;
   assign in_ready  = !mul_valid_ff || mul_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            mul_valid_ff <= in_valid;
         end
         if (mul_ready) begin
            out_valid_ff <= mul_valid_ff;
         end
      end
      if (in_ready && in_valid) begin
         a_ff    <= a_in;
         up_ff   <= up_in;
         prod_ff <= prod_in;
         base_ff <= in_side.use_base;
         bad_ff  <= in_side.bad;
      end
      if (mul_ready && mul_valid_ff) begin
         color_ff   <= color_in;
         out_bad_ff <= bad_ff;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_color = color_ff;
   assign out_bad   = out_bad_ff;

endmodule

// ===== sv/height_colormap_gradient_unit.sv =====
// Top level of the height colormap unit: register port, input stage and pipeline.
`timescale 1ns / 1ps

// Maps one signed 16-bit height sample to a 24-bit RGB terrain color along a
// five-segment gradient (deep blue, green, dark green, brown, tan, white).
// Requests arrive on req_* (tdata = height) and results leave on rsp_*
// (tdata = color, tuser = bad_scale). Every request gives exactly one result,
// in order. The user must write the minimum and maximum map heights through
// csr_* only while the unit is empty; the unit itself does not enforce this.
// A write lands at the clock edge where csr_we is high. Throughput is one
// request per cycle while the receiver keeps rsp_tready high. There are
// twelve register stages: one input stage, four stages of the ratio divider
// (four quotient bits each), one segment stage, four stages of the position
// divider, one multiply stage and the output register; rsp_tvalid rises as a
// result enters the output register. The two restoring dividers set the
// depth; each stage is one narrow subtract and compare chain of four steps.
// Reset is synchronous: it empties the pipeline and sets the minimum height
// to 0 and the maximum height to 1. When the receiver holds rsp_tready low,
// each stage keeps its request until the next one frees up, so empty stages
// still fill and req_tready drops only when every stage holds a request.
// A maximum height of zero or below gives the base blue with bad_scale set.

module height_colormap_gradient_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [15:0]                    req_tdata,   // [15:0] height
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [23:0]                    rsp_tdata,   // [23:0] color
   output logic [0:0]                     rsp_tuser,   // [0] bad_scale
   input  logic                           csr_we,
   input  logic [hcg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [15:0]                    csr_wdata
);

   // Configuration registers.
   logic signed [15:0] min_height_ff;
   logic signed [15:0] max_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_height_ff <= 16'sd0;
         max_height_ff <= 16'sd1;
      end else if (csr_we) begin
         unique case (csr_index)
            hcg_pkg::CSR_MIN_HEIGHT: min_height_ff <= signed'(csr_wdata);
            hcg_pkg::CSR_MAX_HEIGHT: max_height_ff <= signed'(csr_wdata);
         endcase
      end
   end

   // Input stage. The integer bit of height / maximum height and the
   // saturation test are settled here, so the divider only has fraction bits left.
   logic signed [15:0]        height;
   logic [14:0]               z_mag;
   logic [14:0]               d_mag;
   hcg_pkg::side_type         side_in;
   logic [hcg_pkg::DIV_W-1:0] rem_in;

   always_comb begin
      height = signed'(req_tdata);
      z_mag  = height[14:0];
      d_mag  = max_height_ff[14:0];

      side_in        = '0;
      side_in.bad    = max_height_ff <= 16'sd0;
      side_in.pos_z  = height > 16'sd0;
      side_in.gt_min = height > min_height_ff;
      // A ratio of two or more saturates at the top of Q1.FRAC_BITS.
      side_in.sat    = {1'b0, z_mag} >= {d_mag, 1'b0};
      side_in.ibit   = z_mag >= d_mag;

      if (side_in.pos_z && !side_in.sat && !side_in.bad) begin
         rem_in = side_in.ibit ? hcg_pkg::DIV_W'(z_mag - d_mag) : hcg_pkg::DIV_W'(z_mag);
      end else begin
         rem_in = '0;
      end
   end

   logic                      in_valid_ff;
   logic [hcg_pkg::DIV_W-1:0] in_rem_ff;
   logic [hcg_pkg::DIV_W-1:0] in_div_ff;
   hcg_pkg::side_type         in_side_ff;
   logic                      ratio_ready;

   assign req_tready = !in_valid_ff || ratio_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_rem_ff  <= rem_in;
         in_div_ff  <= hcg_pkg::DIV_W'(d_mag);
         in_side_ff <= side_in;
      end
   end

   // Ratio divider: fraction bits of height / maximum height.
   logic                          ratio_valid;
   logic [hcg_pkg::FRAC_BITS-1:0] ratio_quo;
   hcg_pkg::side_type             ratio_side;
   logic                          seg_ready;

   hcg_divider u_ratio_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_ready  (ratio_ready),
      .in_rem    (in_rem_ff),
      .in_div    (in_div_ff),
      .in_side   (in_side_ff),
      .out_valid (ratio_valid),
      .out_ready (seg_ready),
      .out_quo   (ratio_quo),
      .out_side  (ratio_side)
   );

   // Segment choice and offset within the segment.
   logic                      seg_valid;
   logic [hcg_pkg::DIV_W-1:0] seg_rem;
   logic [hcg_pkg::DIV_W-1:0] seg_div;
   hcg_pkg::side_type         seg_side;
   logic                      pos_ready;

   hcg_segment u_segment (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ratio_valid),
      .in_ready  (seg_ready),
      .in_quo    (ratio_quo),
      .in_side   (ratio_side),
      .out_valid (seg_valid),
      .out_ready (pos_ready),
      .out_rem   (seg_rem),
      .out_div   (seg_div),
      .out_side  (seg_side)
   );

   // Position divider: offset / segment width in Q0.FRAC_BITS.
   logic                          pos_valid;
   logic [hcg_pkg::FRAC_BITS-1:0] pos_quo;
   hcg_pkg::side_type             pos_side;
   logic                          blend_ready;

   hcg_divider u_pos_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (seg_valid),
      .in_ready  (pos_ready),
      .in_rem    (seg_rem),
      .in_div    (seg_div),
      .in_side   (seg_side),
      .out_valid (pos_valid),
      .out_ready (blend_ready),
      .out_quo   (pos_quo),
      .out_side  (pos_side)
   );

   // Channel interpolation and the output register.
   hcg_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pos_valid),
      .in_ready  (blend_ready),
      .in_quo    (pos_quo),
      .in_side   (pos_side),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_color (rsp_tdata),
      .out_bad   (rsp_tuser[0])
   );

endmodule

// ===== sv/hcg_checker.sv =====
// Port-level checker of the height colormap unit and its bind statement.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hcg_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   logic stalled;
   logic rsp_bad;

   assign stalled = rsp_tvalid && !rsp_tready;
   assign rsp_bad = rsp_tvalid && rsp_tuser[0];

   // A stalled result keeps its value.
   `AST_NEXT(a_rsp_hold, stalled, rsp_tvalid && $stable({rsp_tdata, rsp_tuser}), "stall lost")

   // A bad scale always comes with the base color.
   `AST_IMPLY(a_bad_base, rsp_bad, rsp_tdata == hcg_pkg::BASE_COLOR, "bad scale not base")

   // The unit pushes back only when the pipeline is full and the output stalled; this checks the stall.
   `AST_IMPLY(a_backpressure, !req_tready, stalled, "req stalled without output stall")

   // Reset empties the pipeline.
   `AST_ALWAYS_NEXT(a_reset_empty, reset, !rsp_tvalid, "result valid after reset")

endmodule

bind height_colormap_gradient_unit hcg_checker u_checker (.*);

// ===== dv/tb.sv =====
// Self-checking testbench for the height colormap unit: stimulus, result checker and top.
`timescale 1ns / 1ps

// One expected result, tagged with the height that caused it so that a
// mismatch line can name the request.
typedef struct packed {
   logic [15:0] height;
   logic        bad_scale;
   logic [23:0] color;
} shade_type;

// Holds the colormap settings as the unit should see them, predicts the color
// of every accepted request and checks the results in order.
class colormap_ledger;

   localparam int SCALE_BITS = 16;
   localparam longint UNITY = longint'(1) << SCALE_BITS;
   localparam logic [23:0] DEEP_BLUE = 24'h00307f;

   int        min_height;
   int        max_height;
   int        error_count;
   shade_type awaited[$];

   function new();
      min_height  = 0;
      max_height  = 1;
      error_count = 0;
   endfunction

   function void set_register(logic [hcg_pkg::CSR_IDX_W-1:0] idx, logic [15:0] value);
      if (idx == hcg_pkg::CSR_MIN_HEIGHT) begin
         min_height = int'($signed(value));
      end else if (idx == hcg_pkg::CSR_MAX_HEIGHT) begin
         max_height = int'($signed(value));
      end
   endfunction

   // Segment boundary as a Q1.16 ratio, rounded from permille.
   function longint knee(int idx);
      longint permille;
      case (idx)
         0:       permille = 0;
         1:       permille = 2;
         2:       permille = 30;
         3:       permille = 100;
         4:       permille = 400;
         default: permille = 1000;
      endcase
      return (permille * UNITY + 500) / 1000;
   endfunction

   function logic [23:0] stop_color(int idx);
      logic [23:0] c;
      case (idx)
         0:       c = DEEP_BLUE;
         1:       c = 24'h087c00;
         2:       c = 24'h055100;
         3:       c = 24'h603d00;
         4:       c = 24'h685c47;
         default: c = 24'hffffff;
      endcase
      return c;
   endfunction

   // Blends the two end colors of segment s at the given ratio. The position
   // inside the segment is clamped to 0..1 and each channel step is truncated
   // toward zero, whichever way the channel runs.
   function logic [23:0] blend(int s, longint ratio);
      longint      lo;
      longint      hi;
      longint      pos;
      longint      a;
      longint      b;
      longint      v;
      logic [23:0] c1;
      logic [23:0] c2;
      logic [23:0] mix;
      lo = knee(s);
      hi = knee(s + 1);
      if (ratio <= lo) begin
         pos = 0;
      end else if (hi <= lo) begin
         pos = UNITY;
      end else begin
         pos = ((ratio - lo) << SCALE_BITS) / (hi - lo);
         if (pos > UNITY) begin
            pos = UNITY;
         end
      end
      c1 = stop_color(s);
      c2 = stop_color(s + 1);
      for (int ch = 0; ch < 3; ch++) begin
         a = longint'(c1[8*ch +: 8]);
         b = longint'(c2[8*ch +: 8]);
         if (b >= a) begin
            v = a + (((b - a) * pos) >> SCALE_BITS);
         end else begin
            v = a - (((a - b) * pos) >> SCALE_BITS);
         end
         mix[8*ch +: 8] = v[7:0];
      end
      return mix;
   endfunction

   function shade_type predict_shade(logic [15:0] height);
      longint    z;
      longint    ratio;
      shade_type res;
      res.height    = height;
      res.bad_scale = 1'b0;
      res.color     = DEEP_BLUE;
      if (max_height <= 0) begin
         res.bad_scale = 1'b1;
         return res;
      end
      z     = longint'($signed(height));
      ratio = 0;
      if (z > 0) begin
         ratio = (z << SCALE_BITS) / max_height;
         if (ratio > 2 * UNITY - 1) begin
            ratio = 2 * UNITY - 1;
         end
      end
      // Segments are tried in order and the last one that matches wins.
      if (z > min_height && ratio <= knee(1)) begin
         res.color = blend(0, ratio);
      end
      for (int s = 1; s <= 4; s++) begin
         if (ratio >= knee(s) && (s == 4 || ratio <= knee(s + 1))) begin
            res.color = blend(s, ratio);
         end
      end
      return res;
   endfunction

   function void note_request(logic [15:0] height);
      awaited.push_back(predict_shade(height));
   endfunction

   function int outstanding();
      return awaited.size();
   endfunction

   task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      error_count++;
   endtask

   task check_result(logic [23:0] color, logic bad_scale);
      shade_type want;
      if (awaited.size() == 0) begin
         report_mismatch($sformatf("result color %06h with no request outstanding", color));
         return;
      end
      want = awaited.pop_front();
      if (color !== want.color) begin
         report_mismatch($sformatf("height %0d: color %06h, expected %06h",
                                   $signed(want.height), color, want.color));
      end
      if (bad_scale !== want.bad_scale) begin
         report_mismatch($sformatf("height %0d: bad_scale %b, expected %b",
                                   $signed(want.height), bad_scale, want.bad_scale));
      end
   endtask

endclass

module tb;

   // The drain pause outlasts the path from an accepted request to the earliest
   // handshake of its result, with some margin on top.
   localparam int DRAIN_CYCLES   = 16;
   // Cycles without any accepted request or result before the run is
   // declared hung. Random stalls are short, so this is generous.
   localparam int WATCHDOG_LIMIT = 2000;

   logic                          clock      = 1'b0;
   logic                          reset      = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [15:0]                   req_tdata  = '0;   // [15:0] height
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [23:0]                   rsp_tdata;         // [23:0] color
   logic [0:0]                    rsp_tuser;         // [0] bad_scale
   logic                          csr_we     = 1'b0;
   logic [hcg_pkg::CSR_IDX_W-1:0] csr_index  = '0;
   logic [15:0]                   csr_wdata  = '0;

   // While set, neither side inserts idle cycles.
   bit             steady_flow = 1'b0;
   int             quiet_cycles = 0;
   colormap_ledger ledger;

   always #5 clock = ~clock;

   height_colormap_gradient_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Offers one height, possibly after a few idle cycles, and returns at the
   // clock edge where the request is taken. Valid stays high between back to
   // back requests, so the next call either keeps it up or starts a gap.
   task automatic send_height(input logic [15:0] height);
      while (!steady_flow && $urandom_range(0, 99) < 14) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= height;
      do begin
         @(posedge clock);
      end while (!req_tready);
      ledger.note_request(height);
   endtask

   // The write lands at the edge after the one where the enable is raised.
   task automatic write_register(input logic [hcg_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [15:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      ledger.set_register(idx, value);
   endtask

   // Waits until every result has come back and the pipeline has emptied.
   // A result that never arrives is caught by the watchdog.
   task automatic settle();
      while (ledger.outstanding() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_depths(input logic [15:0] dmin, input logic [15:0] dmax);
      write_register(hcg_pkg::CSR_MIN_HEIGHT, dmin);
      write_register(hcg_pkg::CSR_MAX_HEIGHT, dmax);
   endtask

   // Random heights shaped after the current scale: most land inside
   // 0..max_height, many right at a segment boundary or near zero, some above
   // max_height, and the rest anywhere in the 16-bit range.
   function automatic logic [15:0] pick_height();
      int kind;
      int span;
      int seg;
      int z;
      kind = $urandom_range(0, 19);
      span = (ledger.max_height > 0) ? ledger.max_height : 32767;
      if (kind < 4) begin
         z = int'($urandom_range(0, 65535)) - 32768;
      end else if (kind < 7) begin
         z = int'($urandom_range(0, span / 64 + 4)) - 3;
      end else if (kind < 10) begin
         seg = $urandom_range(1, 4);
         z = int'((ledger.knee(seg) * span) >> 16) + int'($urandom_range(0, 4)) - 2;
      end else if (kind < 12) begin
         z = span + int'($urandom_range(0, 32767 - span));
      end else begin
         z = int'($urandom_range(0, span));
      end
      if (z > 32767) begin
         z = 32767;
      end else if (z < -32768) begin
         z = -32768;
      end
      return z[15:0];
   endfunction

   task automatic send_random(input int count);
      repeat (count) send_height(pick_height());
   endtask

   // Closes a phase: drops valid at the edge that took the last request and
   // waits for the unit to drain before the next register write.
   task automatic end_phase();
      req_tvalid <= 1'b0;
      settle();
   endtask

   // Result side: checks every accepted result against the oldest prediction
   // and throttles ready at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            ledger.check_result(rsp_tdata, rsp_tuser[0]);
         end
         rsp_tready <= steady_flow || ($urandom_range(0, 99) >= 14);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      ledger = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset scale, maximum height 1: any positive height is at or above the
      // top, so it clamps to white; zero and negative heights give base blue.
      send_height(16'd0);
      send_height(16'd1);
      send_height(16'hffff);
      send_height(16'h7fff);
      send_height(16'h8000);
      send_random(40);
      end_phase();

      // Widest scale. With the maximum height near 2^15 the ratio is about twice the
      // height, so these land on every segment boundary and on both sides of the lower two.
      set_depths(16'h8000, 16'h7fff);
      send_height(16'd0);
      send_height(16'd1);
      send_height(16'd65);
      send_height(16'd66);
      send_height(16'd982);
      send_height(16'd983);
      send_height(16'd3277);
      send_height(16'd13107);
      send_height(16'd16384);
      send_height(16'h7fff);
      send_height(16'h8000);
      send_random(150);
      end_phase();

      // Minimum height at the top: the first segment can never open, so low
      // heights stay base blue instead of blending toward green.
      set_depths(16'h7fff, 16'h7fff);
      send_height(16'd60);
      send_height(16'd0);
      send_height(16'h7fff);
      send_random(60);
      end_phase();

      // Zero and negative maximum height: every request flags a bad scale.
      set_depths(16'd0, 16'd0);
      send_height(16'd100);
      send_height(16'hfffb);
      send_random(40);
      end_phase();

      set_depths(16'hffff, 16'h8000);
      send_height(16'h7fff);
      send_random(40);
      end_phase();

      // A run with both sides always ready, back to back requests.
      set_depths(16'hff9c, 16'd1000);
      steady_flow = 1'b1;
      send_random(150);
      end_phase();
      steady_flow = 1'b0;

      // Small scale with a positive minimum height that gates the first segment.
      set_depths(16'd5, 16'd200);
      send_random(120);
      end_phase();

      repeat (2) begin
         set_depths(16'($urandom_range(0, 40) - 20), 16'($urandom_range(1, 32767)));
         send_random(100);
         end_phase();
      end

      if (ledger.error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== height_colormap_gradient_unit.f =====
+incdir+sv
sv/hcg_pkg.sv
sv/hcg_divider.sv
sv/hcg_segment.sv
sv/hcg_blend.sv
sv/height_colormap_gradient_unit.sv
sv/hcg_checker.sv
dv/tb.sv
